// File: design/iqcsd_pkg.sv
// ----------------------------------------------------------------------------
// iqcsd_pkg
// Shared widths, register indexes and stage types of the I/Q coherent sum
// decimator.
// ----------------------------------------------------------------------------
package iqcsd_pkg;

   localparam int MAX_DECIM   = 1024;
   localparam int SAMPLE_W    = 8;
   localparam int FACTOR_W    = 11;
   localparam int GAIN_W      = 20;
   localparam int OFFSET_W    = 40;
   localparam int VALUE_W     = 41;
   localparam int FRAC_W      = 16;
   localparam int COUNT_W     = $clog2(MAX_DECIM);
   localparam int SUM_W       = SAMPLE_W + COUNT_W + 1;
   localparam int PROD_W      = SUM_W + GAIN_W + 1;
   localparam int CSR_INDEX_W = 3;

   localparam logic [FACTOR_W-1:0] DECIM_LIMIT = FACTOR_W'(MAX_DECIM);

   localparam logic signed [VALUE_W-1:0] BYTE_MAX = VALUE_W'(127);
   localparam logic signed [VALUE_W-1:0] BYTE_MIN = -VALUE_W'(128);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DECIM_FACTOR = 3'd0,
      REG_SCALE_GAIN   = 3'd1,
      REG_OFFSET_I     = 3'd2,
      REG_OFFSET_Q     = 3'd3,
      REG_BYTE_OUTPUT  = 3'd4,
      REG_SWAP_IQ      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [FACTOR_W-1:0]        decim_factor;
      logic [GAIN_W-1:0]          scale_gain;
      logic signed [OFFSET_W-1:0] offset_i;
      logic signed [OFFSET_W-1:0] offset_q;
      logic                       byte_output;
      logic                       swap_iq;
   } cfg_type;

   // Completed block sums handed from the accumulator to the scaler.
   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] sum_i;
      logic signed [SUM_W-1:0] sum_q;
   } dump_type;

   // Scaled, offset-corrected values handed to the output formatter.
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] val_i;
      logic signed [VALUE_W-1:0] val_q;
   } value_type;

endpackage

// File: design/iq_coherent_sum_decimator.sv
// ----------------------------------------------------------------------------
// iq_coherent_sum_decimator
// Integrate-and-dump decimator for complex 8-bit I/Q samples.
// ----------------------------------------------------------------------------
// Usage:
// Complex samples arrive on the req_ stream, one transaction per sample, and
// one transaction per sample is taken in every cycle while the pipeline
// moves. After decim_factor samples the two block sums are scaled by the
// Q4.16 gain, the offset terms are subtracted, and one result transaction
// leaves on the rsp_ stream; no result follows the other samples.
// The result of a block passes through one register stage each for the
// block sums, the gain products, the offset subtraction and the formatted
// result, in that order; one sample is taken per cycle while nothing stalls.
// When the receiver stalls with a result pending, the whole pipeline holds
// and req_tready drops until that result is taken; nothing is lost.
// Registers are written on the csr_ channel, which is always ready, and
// must only be written while no block result is still in flight.
// A synchronous reset restores the register defaults (factor one, unity
// gain, no offset, full precision, no swap), clears the sums and the
// sample count and empties the pipeline.
// ----------------------------------------------------------------------------
module iq_coherent_sum_decimator
   import iqcsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Sample input stream.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [2*SAMPLE_W-1:0]      req_tdata,   // [7:0] sample_i, [15:8] sample_q
   // Result stream.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [87:0]                rsp_tdata,   // [40:0] first_value,
                                                   // [81:41] second_value, zero pad
   output logic [0:0]                 rsp_tuser,   // [0] clipped
   // Register write channel.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [OFFSET_W-1:0]        csr_data
);

   cfg_type                   cfg_ff;
   logic                      advance;
   dump_type                  dump;
   value_type                 value;
   logic signed [VALUE_W-1:0] out_first, out_second;
   logic                      out_clipped;

   // The pipeline moves whenever the result register is empty or drained.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   // Register file. Writes to indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decim_factor <= FACTOR_W'(1);
         cfg_ff.scale_gain   <= GAIN_W'(65536);
         cfg_ff.offset_i     <= '0;
         cfg_ff.offset_q     <= '0;
         cfg_ff.byte_output  <= 1'b0;
         cfg_ff.swap_iq      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_DECIM_FACTOR: cfg_ff.decim_factor <= csr_data[FACTOR_W-1:0];
            REG_SCALE_GAIN:   cfg_ff.scale_gain   <= csr_data[GAIN_W-1:0];
            REG_OFFSET_I:     cfg_ff.offset_i     <= $signed(csr_data);
            REG_OFFSET_Q:     cfg_ff.offset_q     <= $signed(csr_data);
            REG_BYTE_OUTPUT:  cfg_ff.byte_output  <= csr_data[0];
            REG_SWAP_IQ:      cfg_ff.swap_iq      <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   iqcsd_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sample_valid (req_tvalid),
      .sample_i     ($signed(req_tdata[SAMPLE_W-1:0])),
      .sample_q     ($signed(req_tdata[2*SAMPLE_W-1:SAMPLE_W])),
      .decim_factor (cfg_ff.decim_factor),
      .dump         (dump)
   );

   iqcsd_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .scale_gain (cfg_ff.scale_gain),
      .offset_i   (cfg_ff.offset_i),
      .offset_q   (cfg_ff.offset_q),
      .dump       (dump),
      .value      (value)
   );

   iqcsd_format u_format (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .byte_output (cfg_ff.byte_output),
      .swap_iq     (cfg_ff.swap_iq),
      .value       (value),
      .out_valid   (rsp_tvalid),
      .out_first   (out_first),
      .out_second  (out_second),
      .out_clipped (out_clipped)
   );

   // Two values packed from bit zero, then zero fill up to whole bytes.
   assign rsp_tdata = {{(88 - 2*VALUE_W){1'b0}}, out_second, out_first};
   assign rsp_tuser = out_clipped;

endmodule

// File: design/iqcsd_accum.sv
// ----------------------------------------------------------------------------
// iqcsd_accum
// Integrate-and-dump accumulators with the block sample counter.
// ----------------------------------------------------------------------------
module iqcsd_accum
   import iqcsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       sample_valid,
   input  logic signed [SAMPLE_W-1:0] sample_i,
   input  logic signed [SAMPLE_W-1:0] sample_q,
   input  logic [FACTOR_W-1:0]        decim_factor,
   output dump_type                   dump
);

   logic signed [SUM_W-1:0] sum_i_ff, sum_q_ff;
   logic signed [SUM_W-1:0] sum_i_in, sum_q_in;
   logic [COUNT_W-1:0]      count_ff;
   logic [FACTOR_W-1:0]     count_inc;
   logic [FACTOR_W-1:0]     eff_factor;
   logic                    take, done;
   dump_type                dump_ff, dump_in;

   assign take = sample_valid & advance;

   always_comb begin
      // A zero factor acts as one, anything above the limit as the limit.
      if (decim_factor == '0) begin
         eff_factor = FACTOR_W'(1);
      end else if (decim_factor > DECIM_LIMIT) begin
         eff_factor = DECIM_LIMIT;
      end else begin
         eff_factor = decim_factor;
      end
      count_inc = FACTOR_W'(count_ff) + FACTOR_W'(1);
      // Greater-or-equal also closes a block after the factor was lowered.
      done      = (count_inc >= eff_factor);
      sum_i_in  = sum_i_ff + {{(SUM_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
      sum_q_in  = sum_q_ff + {{(SUM_W - SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
      dump_in.valid = take & done;
      dump_in.sum_i = sum_i_in;
      dump_in.sum_q = sum_q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_i_ff      <= '0;
         sum_q_ff      <= '0;
         count_ff      <= '0;
         dump_ff.valid <= 1'b0;
      end else begin
         if (take) begin
            if (done) begin
               sum_i_ff <= '0;
               sum_q_ff <= '0;
               count_ff <= '0;
            end else begin
               sum_i_ff <= sum_i_in;
               sum_q_ff <= sum_q_in;
               count_ff <= count_inc[COUNT_W-1:0];
            end
         end
         if (advance) begin
            dump_ff.valid <= dump_in.valid;
         end
      end
      if (advance) begin
         dump_ff.sum_i <= dump_in.sum_i;
         dump_ff.sum_q <= dump_in.sum_q;
      end
   end

   assign dump = dump_ff;

   a_dump_clears: assert property (@(posedge clock) disable iff (reset)
      (take && done) |=> (sum_i_ff == '0 && sum_q_ff == '0 && count_ff == '0))
      else $error("accumulators not cleared after a dump");

   a_dump_needs_take: assert property (@(posedge clock) disable iff (reset)
      (advance && !take) |=> !dump_ff.valid)
      else $error("dump raised without an accepted sample");

endmodule

// File: design/iqcsd_scale.sv
// ----------------------------------------------------------------------------
// iqcsd_scale
// Gain multiply and offset subtraction, one register after each step.
// ----------------------------------------------------------------------------
module iqcsd_scale
   import iqcsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [GAIN_W-1:0]          scale_gain,
   input  logic signed [OFFSET_W-1:0] offset_i,
   input  logic signed [OFFSET_W-1:0] offset_q,
   input  dump_type                   dump,
   output value_type                  value
);

   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prod_i_ff, prod_q_ff;
   logic signed [PROD_W-1:0] prod_i_in, prod_q_in;
   logic signed [GAIN_W:0]   gain_s;
   value_type                value_ff, value_in;

   assign gain_s    = $signed({1'b0, scale_gain});
   assign prod_i_in = dump.sum_i * gain_s;
   assign prod_q_in = dump.sum_q * gain_s;

   // With the register ranges the difference always fits the output width,
   // so no saturation stage is needed.
   always_comb begin
      value_in.valid = prod_valid_ff;
      value_in.val_i = {{(VALUE_W - PROD_W){prod_i_ff[PROD_W-1]}}, prod_i_ff}
                     - {{(VALUE_W - OFFSET_W){offset_i[OFFSET_W-1]}}, offset_i};
      value_in.val_q = {{(VALUE_W - PROD_W){prod_q_ff[PROD_W-1]}}, prod_q_ff}
                     - {{(VALUE_W - OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff  <= 1'b0;
         value_ff.valid <= 1'b0;
      end else if (advance) begin
         prod_valid_ff  <= dump.valid;
         value_ff.valid <= value_in.valid;
      end
      if (advance) begin
         prod_i_ff      <= prod_i_in;
         prod_q_ff      <= prod_q_in;
         value_ff.val_i <= value_in.val_i;
         value_ff.val_q <= value_in.val_q;
      end
   end

   assign value = value_ff;

endmodule

// File: design/iqcsd_format.sv
// ----------------------------------------------------------------------------
// iqcsd_format
// Byte truncation and clipping, I/Q swap and the result register.
// ----------------------------------------------------------------------------
module iqcsd_format
   import iqcsd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       byte_output,
   input  logic                       swap_iq,
   input  value_type                  value,
   output logic                       out_valid,
   output logic signed [VALUE_W-1:0]  out_first,
   output logic signed [VALUE_W-1:0]  out_second,
   output logic                       out_clipped
);

   typedef struct packed {
      logic signed [VALUE_W-1:0] val;
      logic                      clip;
   } byte_result_type;

   // Truncate toward zero: bias negative values by one less than a unit.
   function automatic byte_result_type to_byte(input logic signed [VALUE_W-1:0] v);
      logic signed [VALUE_W-1:0] biased;
      logic signed [VALUE_W-1:0] whole;
      byte_result_type           r;
      biased = v + (v[VALUE_W-1] ? VALUE_W'({FRAC_W{1'b1}}) : VALUE_W'(0));
      whole  = biased >>> FRAC_W;
      r.clip = 1'b0;
      r.val  = whole;
      if (whole > BYTE_MAX) begin
         r.val  = BYTE_MAX;
         r.clip = 1'b1;
      end else if (whole < BYTE_MIN) begin
         r.val  = BYTE_MIN;
         r.clip = 1'b1;
      end
      return r;
   endfunction

   byte_result_type           byte_i, byte_q;
   logic signed [VALUE_W-1:0] sel_i, sel_q;
   logic signed [VALUE_W-1:0] first_in, second_in;
   logic                      clipped_in;
   logic                      valid_ff;
   logic signed [VALUE_W-1:0] first_ff, second_ff;
   logic                      clipped_ff;

   always_comb begin
      byte_i     = to_byte(value.val_i);
      byte_q     = to_byte(value.val_q);
      sel_i      = byte_output ? byte_i.val : value.val_i;
      sel_q      = byte_output ? byte_q.val : value.val_q;
      clipped_in = byte_output & (byte_i.clip | byte_q.clip);
      first_in   = swap_iq ? sel_q : sel_i;
      second_in  = swap_iq ? sel_i : sel_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= value.valid;
      end
      if (advance) begin
         first_ff   <= first_in;
         second_ff  <= second_in;
         clipped_ff <= clipped_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_first   = first_ff;
   assign out_second  = second_ff;
   assign out_clipped = clipped_ff;

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && clipped_ff) |->
         (first_ff == BYTE_MAX || first_ff == BYTE_MIN ||
          second_ff == BYTE_MAX || second_ff == BYTE_MIN))
      else $error("clip flag set without a value at a byte limit");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !advance) |=> (valid_ff && $stable(first_ff) && $stable(second_ff)))
      else $error("pending result changed while the receiver stalled");

endmodule

// File: tb/tb_iq_coherent_sum_decimator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iq_coherent_sum_decimator
// Self-checking testbench for the I/Q coherent sum decimator.
// Complex samples are streamed in bursts while the result side stalls on a
// pattern of its own. Every accepted sample is fed to a local model of the
// block sums, the gain, the offset terms and the byte formatting, and every
// result transaction is compared with the oldest predicted block result.
// ----------------------------------------------------------------------------
module tb_iq_coherent_sum_decimator;
   import iqcsd_pkg::*;

   // Timing and run length.
   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 3;
   // The last sample of a block reaches the result register through the sum,
   // product and offset registers; the drain wait covers what is still in the pipeline.
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 300;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_ITEMS    = 40;

   // Register indexes that decode to nothing; writes to them must be ignored.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 8'sh7F;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 8'sh80;

   localparam logic [GAIN_W-1:0]   UNITY_GAIN  = 20'h10000;
   localparam logic [GAIN_W-1:0]   HALF_GAIN   = 20'h08000;
   localparam logic [GAIN_W-1:0]   GAIN_MAX    = 20'hFFFFF;
   localparam logic [FACTOR_W-1:0] FACTOR_TOP  = 11'h7FF;
   localparam logic [OFFSET_W-1:0] OFFSET_HIGH = 40'h7F_FFFF_FFFF;
   localparam logic [OFFSET_W-1:0] OFFSET_LOW  = 40'h80_0000_0000;

   localparam longint VALUE_HIGH = 64'sd1099511627775;
   localparam longint VALUE_LOW  = -64'sd1099511627776;

   // Receiver stall patterns.
   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SELDOM,
      READY_PERIODIC
   } ready_mode_type;

   // One predicted block result, as it should appear on the rsp_ stream.
   typedef struct {
      logic signed [VALUE_W-1:0] first_value;
      logic signed [VALUE_W-1:0] second_value;
      logic                      clipped;
   } dump_result_type;

   // DUT connections. Every input starts at a known value.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [2*SAMPLE_W-1:0]  req_tdata  = '0;   // [7:0] sample_i, [15:8] sample_q
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [87:0]            rsp_tdata;         // [40:0] first_value,
                                              // [81:41] second_value, zero pad
   logic [0:0]             rsp_tuser;         // [0] clipped
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [OFFSET_W-1:0]    csr_data   = '0;

   // Local copy of the register file and the accumulators.
   logic [FACTOR_W-1:0]        model_factor;
   logic [GAIN_W-1:0]          model_gain;
   logic signed [OFFSET_W-1:0] model_off_i;
   logic signed [OFFSET_W-1:0] model_off_q;
   logic                       model_byte_mode;
   logic                       model_swap;
   logic signed [SUM_W-1:0]    model_sum_i;
   logic signed [SUM_W-1:0]    model_sum_q;
   int                         model_count;

   // Block results predicted but not yet seen, oldest first.
   dump_result_type expected_dumps[$];
   dump_result_type dump_want;

   // Bookkeeping.
   int error_count     = 0;
   int samples_sent    = 0;
   int results_checked = 0;
   int random_phases   = 0;

   // Sender burst state.
   int burst_left    = 0;
   bit steady_sender = 1'b0;

   // Receiver state. A test sets hold_request to ask for a long hold-off;
   // the receiver process takes it over and counts it down on its own.
   int             hold_request = 0;
   int             hold_left    = 0;
   ready_mode_type ready_mode   = READY_ALWAYS;
   int             mode_left    = 0;
   int             ready_phase  = 0;

   int idle_cycles = 0;

   iq_coherent_sum_decimator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Block sum times the Q4.16 gain minus the offset term, in units of 2^-16,
   // held to the 41-bit output range.
   function automatic longint scale_sum(longint sum, longint off);
      longint v;
      v = sum * longint'(model_gain) - off;
      if (v > VALUE_HIGH) v = VALUE_HIGH;
      if (v < VALUE_LOW) v = VALUE_LOW;
      return v;
   endfunction

   // Byte mode: drop the fraction toward zero, then clip to a signed byte.
   function automatic longint byte_clip(longint v, inout logic clip);
      longint n;
      n = v / (longint'(1) << FRAC_W);
      if (n > longint'(BYTE_MAX)) begin
         n    = longint'(BYTE_MAX);
         clip = 1'b1;
      end
      if (n < longint'(BYTE_MIN)) begin
         n    = longint'(BYTE_MIN);
         clip = 1'b1;
      end
      return n;
   endfunction

   // Adds one accepted sample to the model sums and, when the block is
   // complete, queues the result the block must produce.
   task automatic integrate_sample(input logic signed [SAMPLE_W-1:0] si,
                                   input logic signed [SAMPLE_W-1:0] sq);
      int              eff;
      longint          vi;
      longint          vq;
      logic            clip;
      dump_result_type dump;
      // A zero factor behaves as one, an oversized one as the maximum.
      eff = int'(model_factor);
      if (eff == 0) eff = 1;
      if (eff > MAX_DECIM) eff = MAX_DECIM;
      model_sum_i = model_sum_i + si;
      model_sum_q = model_sum_q + sq;
      model_count++;
      // Comparing with >= also covers a factor lowered below a running count.
      if (model_count >= eff) begin
         clip = 1'b0;
         vi   = scale_sum(longint'(model_sum_i), longint'(model_off_i));
         vq   = scale_sum(longint'(model_sum_q), longint'(model_off_q));
         if (model_byte_mode) begin
            vi = byte_clip(vi, clip);
            vq = byte_clip(vq, clip);
         end
         dump.first_value  = model_swap ? VALUE_W'(vq) : VALUE_W'(vi);
         dump.second_value = model_swap ? VALUE_W'(vi) : VALUE_W'(vq);
         dump.clipped      = clip;
         expected_dumps.push_back(dump);
         model_sum_i = '0;
         model_sum_q = '0;
         model_count = 0;
      end
   endtask

   // Register write as the block sees it; narrow registers keep only their
   // low bits and unknown indexes change nothing.
   function automatic void apply_reg_write(logic [CSR_INDEX_W-1:0] idx,
                                           logic [OFFSET_W-1:0] value);
      case (idx)
         REG_DECIM_FACTOR: model_factor    = value[FACTOR_W-1:0];
         REG_SCALE_GAIN:   model_gain      = value[GAIN_W-1:0];
         REG_OFFSET_I:     model_off_i     = value;
         REG_OFFSET_Q:     model_off_q     = value;
         REG_BYTE_OUTPUT:  model_byte_mode = value[0];
         REG_SWAP_IQ:      model_swap      = value[0];
         default: ;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Places a narrow register value in the low bits and random noise above.
   function automatic logic [OFFSET_W-1:0] with_junk(logic [OFFSET_W-1:0] field,
                                                     int width);
      logic [OFFSET_W-1:0] noise;
      noise = OFFSET_W'({$urandom(), $urandom()});
      return (noise << width) | field;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // Offsets: zero, the two extremes, small values that keep byte mode out
   // of permanent clipping, and anything in the 40-bit range.
   function automatic logic [OFFSET_W-1:0] pick_offset();
      case ($urandom_range(0, 9))
         0, 1, 2: return '0;
         3:       return OFFSET_LOW;
         4:       return OFFSET_HIGH;
         5, 6:    return OFFSET_W'($signed(25'($urandom())));
         default: return OFFSET_W'({$urandom(), $urandom()});
      endcase
   endfunction

   // Offers one sample and waits for its transaction. The sender works in
   // bursts; between bursts tvalid may drop for a random gap.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                              input logic signed [SAMPLE_W-1:0] sq);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (steady_sender)
            gap = 0;
         else if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(10, 30);
         else
            gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {sq, si};
      do @(posedge clock); while (!req_tready);
      integrate_sample(si, sq);
      samples_sent++;
      burst_left--;
   endtask

   // One register write transaction, followed by a quiet cycle so that the
   // valid never drops and rises again in the same time step.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [OFFSET_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg_write(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [FACTOR_W-1:0] factor,
                            input logic [GAIN_W-1:0] gain,
                            input logic [OFFSET_W-1:0] off_i,
                            input logic [OFFSET_W-1:0] off_q,
                            input logic byte_mode,
                            input logic swap,
                            input bit junk);
      write_reg(REG_DECIM_FACTOR,
                junk ? with_junk(OFFSET_W'(factor), FACTOR_W) : OFFSET_W'(factor));
      write_reg(REG_SCALE_GAIN,
                junk ? with_junk(OFFSET_W'(gain), GAIN_W) : OFFSET_W'(gain));
      write_reg(REG_OFFSET_I, off_i);
      write_reg(REG_OFFSET_Q, off_q);
      write_reg(REG_BYTE_OUTPUT,
                junk ? with_junk(OFFSET_W'(byte_mode), 1) : OFFSET_W'(byte_mode));
      write_reg(REG_SWAP_IQ,
                junk ? with_junk(OFFSET_W'(swap), 1) : OFFSET_W'(swap));
   endtask

   // Waits until every predicted result has arrived, then lets the pipeline
   // settle so that registers may be rewritten safely.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_dumps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset defaults: factor one and unity gain, so each sample comes straight
   // back shifted up by the sixteen fraction bits.
   task automatic test_unity_defaults();
      send_sample(SAMPLE_MAX, SAMPLE_MIN);
      send_sample(SAMPLE_MIN, SAMPLE_MAX);
      send_sample(8'sd0, 8'sd0);
      send_sample(-8'sd1, 8'sd1);
      wait_drained();
   endtask

   // A zero factor acts as one. Largest gain with the offset extremes pushes
   // the full-precision values toward both ends of their range.
   task automatic test_zero_factor_extremes();
      write_all('0, GAIN_MAX, OFFSET_LOW, OFFSET_HIGH, 1'b0, 1'b0, 1'b0);
      send_sample(SAMPLE_MAX, SAMPLE_MIN);
      send_sample(SAMPLE_MIN, SAMPLE_MAX);
      wait_drained();
      // With zero gain only the negated offsets remain.
      write_reg(REG_SCALE_GAIN, '0);
      send_sample(SAMPLE_MAX, SAMPLE_MAX);
      wait_drained();
   endtask

   // Byte mode: clipping at the upper limit, truncation toward zero of negative
   // halves, the swapped order, and offsets alone driving a clip.
   task automatic test_byte_clipping();
      write_all(11'd2, GAIN_MAX, '0, '0, 1'b1, 1'b0, 1'b0);
      send_sample(SAMPLE_MAX, SAMPLE_MAX);
      send_sample(SAMPLE_MAX, SAMPLE_MIN);
      wait_drained();
      write_all(11'd1, HALF_GAIN, '0, '0, 1'b1, 1'b1, 1'b0);
      send_sample(-8'sd3, 8'sd3);
      send_sample(SAMPLE_MIN, 8'sd1);
      wait_drained();
      write_reg(REG_SCALE_GAIN, '0);
      write_reg(REG_OFFSET_I, OFFSET_W'(5 << FRAC_W));
      write_reg(REG_OFFSET_Q, OFFSET_W'(-(200 << FRAC_W)));
      send_sample(8'sd0, 8'sd0);
      wait_drained();
   endtask

   // The factor drops below the count already summed; the very next sample
   // must close the block.
   task automatic test_factor_lowered();
      write_all(11'd8, UNITY_GAIN, '0, '0, 1'b0, 1'b0, 1'b0);
      repeat (5) send_sample(pick_sample(), pick_sample());
      wait_drained();
      write_reg(REG_DECIM_FACTOR, OFFSET_W'(3));
      send_sample(pick_sample(), pick_sample());
      wait_drained();
      write_reg(REG_DECIM_FACTOR, OFFSET_W'(2));
      repeat (2) send_sample(pick_sample(), pick_sample());
      wait_drained();
   endtask

   // Writes to indexes outside the register map must leave everything as is.
   task automatic test_spare_index();
      write_reg(REG_SPARE_6, OFFSET_W'({$urandom(), $urandom()}));
      write_reg(REG_SPARE_7, OFFSET_W'({$urandom(), $urandom()}));
      repeat (2) send_sample(pick_sample(), pick_sample());
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while samples keep coming at
   // full rate, so the pipeline fills and req_tready has to drop.
   task automatic test_input_stall();
      write_all(11'd1, UNITY_GAIN, pick_offset(), pick_offset(), 1'b0, 1'b0, 1'b0);
      steady_sender = 1'b1;
      hold_request  = HOLD_CYCLES;
      repeat (STALL_ITEMS) send_sample(pick_sample(), pick_sample());
      steady_sender = 1'b0;
      wait_drained();
   endtask

   // One full-size block of extreme samples with an oversized factor, which
   // must act as the maximum, giving the largest sums the accumulators see.
   task automatic test_full_block();
      write_all(11'd1, UNITY_GAIN, '0, '0, 1'b0, 1'b0, 1'b0);
      send_sample(8'sd0, 8'sd0);
      wait_drained();
      write_all(FACTOR_TOP, GAIN_MAX, OFFSET_LOW, OFFSET_HIGH, 1'b0,
                logic'($urandom_range(0, 1)), 1'b0);
      repeat (MAX_DECIM) send_sample(SAMPLE_MAX, SAMPLE_MIN);
      wait_drained();
   endtask

   // Random settings phase after phase. Factors are mostly small so that
   // results are frequent; blocks left open carry into the next setting.
   task automatic test_random_phases();
      int                  random_sent;
      int                  phase_items;
      logic [FACTOR_W-1:0] factor;
      logic [GAIN_W-1:0]   gain;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       factor = '0;
            1:       factor = $urandom_range(0, 1) ? FACTOR_W'(MAX_DECIM)
                                                   : FACTOR_W'($urandom_range(1025, 2047));
            2, 3:    factor = FACTOR_W'($urandom_range(41, 200));
            default: factor = $urandom_range(0, 1) ? FACTOR_W'($urandom_range(1, 8))
                                                   : FACTOR_W'($urandom_range(9, 40));
         endcase
         case ($urandom_range(0, 9))
            0:       gain = '0;
            1:       gain = GAIN_MAX;
            2:       gain = UNITY_GAIN;
            default: gain = GAIN_W'($urandom()) >> $urandom_range(0, 12);
         endcase
         write_all(factor, gain, pick_offset(), pick_offset(),
                   logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                   bit'($urandom_range(0, 1)));
         phase_items = $urandom_range(20, 120);
         repeat (phase_items) send_sample(pick_sample(), pick_sample());
         random_sent += phase_items;
         random_phases++;
         wait_drained();
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver: a stall pattern picked anew at random intervals, plus the
   // long hold-off on request.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      ready_phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_MOSTLY: rsp_tready <= ($urandom_range(0, 9) < 7);
            READY_SELDOM: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= (ready_phase % 5 == 0);
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what,
                                  input logic signed [VALUE_W-1:0] got,
                                  input logic signed [VALUE_W-1:0] want);
      error_count++;
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Outputs are sampled at the edge, before the block updates them, so the
   // values seen are the ones of the transaction at that edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_dumps.size() == 0) begin
            report_mismatch("result with no block pending", rsp_tdata[VALUE_W-1:0], '0);
         end else begin
            dump_want = expected_dumps.pop_front();
            results_checked++;
            if (rsp_tdata[VALUE_W-1:0] !== dump_want.first_value)
               report_mismatch("first_value", rsp_tdata[VALUE_W-1:0],
                               dump_want.first_value);
            if (rsp_tdata[2*VALUE_W-1:VALUE_W] !== dump_want.second_value)
               report_mismatch("second_value", rsp_tdata[2*VALUE_W-1:VALUE_W],
                               dump_want.second_value);
            if (rsp_tuser[0] !== dump_want.clipped)
               report_mismatch("clipped", VALUE_W'(rsp_tuser[0]),
                               VALUE_W'(dump_want.clipped));
         end
      end
   end

   // Watchdog: ends the run when no transaction of any kind happens for too
   // long, which means the block or the testbench is stuck.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] Watchdog: no transaction for %0d cycles, %0d results pending",
                  $realtime, WATCHDOG_LIMIT, expected_dumps.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      // Model state after reset: factor one, unity gain, everything else zero.
      model_factor    = 11'd1;
      model_gain      = UNITY_GAIN;
      model_off_i     = '0;
      model_off_q     = '0;
      model_byte_mode = 1'b0;
      model_swap      = 1'b0;
      model_sum_i     = '0;
      model_sum_q     = '0;
      model_count     = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unity_defaults();
      test_zero_factor_extremes();
      test_byte_clipping();
      test_factor_lowered();
      test_spare_index();
      test_input_stall();
      test_full_block();
      test_random_phases();

      wait_drained();
      $display("Sent %0d samples and checked %0d block results over %0d random settings.",
               samples_sent, results_checked, random_phases);
      $display("Covered reset defaults, zero and oversized factors, byte clipping, "
               , "a lowered factor, unused indexes and a full input stall.");
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
